[hdl/ttyld_pkg.sv]
// Shared types, constants and codes for the canonical line discipline
package ttyld_pkg;

    localparam int LINE_DEPTH_DEF = 256;
    localparam int RAW_DEPTH_DEF  = 256;

    localparam logic [7:0] CH_NL = 8'd10;
    localparam logic [7:0] CH_CR = 8'd13;
    localparam logic [7:0] CH_BS = 8'd8;
    localparam logic [7:0] CH_SP = 8'd32;
    localparam logic [7:0] CH_HT = 8'd9;
    localparam logic [8:0] ERASE_MAX = 9'd511;

    // mode flag bit positions
    localparam int F_CANON = 0;
    localparam int F_SIG   = 1;
    localparam int F_ECHO  = 2;
    localparam int F_CRNL  = 3;
    localparam int F_NLCR  = 4;

    // register indexes
    localparam logic [2:0] REG_MODE  = 3'd0;
    localparam logic [2:0] REG_INTR  = 3'd1;
    localparam logic [2:0] REG_QUIT  = 3'd2;
    localparam logic [2:0] REG_ERASE = 3'd3;
    localparam logic [2:0] REG_KILL  = 3'd4;
    localparam logic [2:0] REG_WERASE = 3'd5;
    localparam logic [2:0] REG_EOF   = 3'd6;

    localparam logic OP_CHAR = 1'b0;
    localparam logic OP_READ = 1'b1;

    localparam logic [1:0] SIG_NONE = 2'd0;
    localparam logic [1:0] SIG_INTR = 2'd1;
    localparam logic [1:0] SIG_QUIT = 2'd2;

    typedef struct packed {
        logic       operation;
        logic [7:0] in_char;
    } t_in;

    typedef struct packed {
        logic       echo_valid;
        logic [7:0] echo_char;
        logic [8:0] erase_count;
        logic       read_valid;
        logic [7:0] read_char;
        logic       wake_reader;
        logic [1:0] signal_kind;
    } t_out;

    typedef enum logic [3:0] {
        K_RD_LINE, K_RD_RAW, K_RD_NONE, K_SIG_INTR, K_SIG_QUIT,
        K_ERASE, K_KILL, K_WERASE, K_EOF, K_NORMAL
    } t_kind;

    typedef enum logic [2:0] {
        S_IDLE, S_DECODE, S_SCAN_RD, S_SCAN_CHK, S_READ_DONE, S_FINISH
    } t_state;

    typedef struct packed {
        logic load;
        logic decode;
        logic sel_tail;
        logic scan_step;
        logic pop;
        logic finish;
    } t_cmd;

    typedef struct packed {
        t_kind kind;
        logic  line_empty;
        logic  scan_stop;
        logic  out_busy;
    } t_status;

endpackage

[hdl/ttyld_ctrl.sv]
// Controller state machine sequencing decode, tail scan, read and result hand-off
module ttyld_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  ttyld_pkg::t_status i_status,
    output ttyld_pkg::t_cmd   o_cmd,
    output logic              o_idle
);

    ttyld_pkg::t_state r_state, n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ttyld_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_idle  = 1'b0;
        unique case (r_state)
            ttyld_pkg::S_IDLE: begin
                o_idle = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = ttyld_pkg::S_DECODE;
                end
            end
            ttyld_pkg::S_DECODE: begin
                o_cmd.decode = 1'b1;
                case (i_status.kind)
                    ttyld_pkg::K_RD_LINE, ttyld_pkg::K_RD_RAW:
                        n_state = ttyld_pkg::S_READ_DONE;
                    ttyld_pkg::K_ERASE, ttyld_pkg::K_KILL, ttyld_pkg::K_WERASE:
                        n_state = ttyld_pkg::S_SCAN_RD;
                    default:
                        n_state = ttyld_pkg::S_FINISH;
                endcase
            end
            ttyld_pkg::S_SCAN_RD: begin
                o_cmd.sel_tail = 1'b1;
                n_state = i_status.line_empty ? ttyld_pkg::S_FINISH
                                              : ttyld_pkg::S_SCAN_CHK;
            end
            ttyld_pkg::S_SCAN_CHK: begin
                if (i_status.scan_stop) begin
                    n_state = ttyld_pkg::S_FINISH;
                end else begin
                    o_cmd.scan_step = 1'b1;
                    n_state = (i_status.kind == ttyld_pkg::K_ERASE)
                              ? ttyld_pkg::S_FINISH : ttyld_pkg::S_SCAN_RD;
                end
            end
            ttyld_pkg::S_READ_DONE: begin
                o_cmd.pop = 1'b1;
                n_state   = ttyld_pkg::S_FINISH;
            end
            ttyld_pkg::S_FINISH: begin
                if (!i_status.out_busy) begin
                    o_cmd.finish = 1'b1;
                    n_state      = ttyld_pkg::S_IDLE;
                end
            end
            default: n_state = ttyld_pkg::S_IDLE;
        endcase
    end

endmodule

[hdl/ttyld_dpath.sv]
// Datapath: settings registers, line and raw queues, working result and output register
module ttyld_dpath #(
    parameter int LINE_DEPTH = ttyld_pkg::LINE_DEPTH_DEF,
    parameter int RAW_DEPTH  = ttyld_pkg::RAW_DEPTH_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  ttyld_pkg::t_in     i_in,
    input  logic               i_cfg_valid,
    input  logic [2:0]         i_cfg_index,
    input  logic [7:0]         i_cfg_data,
    input  logic               i_out_stall,
    input  ttyld_pkg::t_cmd    i_cmd,
    output ttyld_pkg::t_status o_status,
    output logic               o_out_valid,
    output ttyld_pkg::t_out    o_out
);

    localparam int LAW = $clog2(LINE_DEPTH);
    localparam int LCW = $clog2(LINE_DEPTH + 1);
    localparam int RAW_AW = $clog2(RAW_DEPTH);
    localparam int RCW = $clog2(RAW_DEPTH + 1);
    localparam logic [LCW:0] L_D = (LCW + 1)'(LINE_DEPTH);
    localparam logic [RCW:0] R_D = (RCW + 1)'(RAW_DEPTH);
    localparam logic [LAW-1:0] L_LAST = LAW'(LINE_DEPTH - 1);
    localparam logic [RAW_AW-1:0] R_LAST = RAW_AW'(RAW_DEPTH - 1);

    // settings
    logic [4:0] r_mode;
    logic [7:0] r_intr, r_quit, r_erase, r_kill, r_werase, r_eof;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= 5'd15;
            r_intr   <= 8'd3;
            r_quit   <= 8'd28;
            r_erase  <= 8'd127;
            r_kill   <= 8'd21;
            r_werase <= 8'd23;
            r_eof    <= 8'd4;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                ttyld_pkg::REG_MODE:   r_mode   <= i_cfg_data[4:0];
                ttyld_pkg::REG_INTR:   r_intr   <= i_cfg_data;
                ttyld_pkg::REG_QUIT:   r_quit   <= i_cfg_data;
                ttyld_pkg::REG_ERASE:  r_erase  <= i_cfg_data;
                ttyld_pkg::REG_KILL:   r_kill   <= i_cfg_data;
                ttyld_pkg::REG_WERASE: r_werase <= i_cfg_data;
                ttyld_pkg::REG_EOF:    r_eof    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // latched item, character already mapped
    logic       r_op;
    logic [7:0] r_ch;
    logic [7:0] n_ch;

    always_comb begin
        n_ch = i_in.in_char;
        if (n_ch == ttyld_pkg::CH_NL && r_mode[ttyld_pkg::F_NLCR]) n_ch = ttyld_pkg::CH_CR;
        if (n_ch == ttyld_pkg::CH_CR && r_mode[ttyld_pkg::F_CRNL]) n_ch = ttyld_pkg::CH_NL;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op <= i_in.operation;
            r_ch <= n_ch;
        end
    end

    // queue state
    logic [LAW-1:0]    r_lhead;
    logic [LCW-1:0]    r_lcnt;
    logic              r_lready;
    logic [RAW_AW-1:0] r_rhead;
    logic [RCW-1:0]    r_rcnt;

    logic canon;
    assign canon = r_mode[ttyld_pkg::F_CANON];

    // classify the latched item
    ttyld_pkg::t_kind kind;
    always_comb begin
        if (r_op == ttyld_pkg::OP_READ) begin
            if (canon) begin
                kind = (r_lcnt != '0 && r_lready) ? ttyld_pkg::K_RD_LINE
                                                  : ttyld_pkg::K_RD_NONE;
            end else begin
                kind = (r_rcnt != '0) ? ttyld_pkg::K_RD_RAW : ttyld_pkg::K_RD_NONE;
            end
        end else if (r_mode[ttyld_pkg::F_SIG] && r_ch == r_intr) begin
            kind = ttyld_pkg::K_SIG_INTR;
        end else if (r_mode[ttyld_pkg::F_SIG] && r_ch == r_quit) begin
            kind = ttyld_pkg::K_SIG_QUIT;
        end else if (!canon) begin
            kind = ttyld_pkg::K_NORMAL;
        end else if (r_ch == r_erase || r_ch == ttyld_pkg::CH_BS) begin
            kind = ttyld_pkg::K_ERASE;
        end else if (r_ch == r_kill) begin
            kind = ttyld_pkg::K_KILL;
        end else if (r_ch == r_werase) begin
            kind = ttyld_pkg::K_WERASE;
        end else if (r_ch == r_eof) begin
            kind = ttyld_pkg::K_EOF;
        end else begin
            kind = ttyld_pkg::K_NORMAL;
        end
    end

    // queue addresses, wrapped by one compare and subtract
    logic [LCW:0]      lsum, lsum_m1;
    logic [LAW-1:0]    l_wr_addr, l_tail_addr, l_rd_addr, l_head_inc;
    logic [RCW:0]      rsum;
    logic [RAW_AW-1:0] r_wr_addr, r_head_inc;

    always_comb begin
        lsum        = (LCW + 1)'(r_lhead) + (LCW + 1)'(r_lcnt);
        lsum_m1     = lsum - (LCW + 1)'(1);
        l_wr_addr   = (lsum >= L_D) ? LAW'(lsum - L_D) : LAW'(lsum);
        l_tail_addr = (lsum_m1 >= L_D) ? LAW'(lsum_m1 - L_D) : LAW'(lsum_m1);
        l_rd_addr   = i_cmd.sel_tail ? l_tail_addr : r_lhead;
        l_head_inc  = (r_lhead == L_LAST) ? '0 : r_lhead + LAW'(1);
        rsum        = (RCW + 1)'(r_rhead) + (RCW + 1)'(r_rcnt);
        r_wr_addr   = (rsum >= R_D) ? RAW_AW'(rsum - R_D) : RAW_AW'(rsum);
        r_head_inc  = (r_rhead == R_LAST) ? '0 : r_rhead + RAW_AW'(1);
    end

    // write enables at decode
    logic       typed_store, l_push, r_push;
    logic [7:0] l_wdata;

    always_comb begin
        typed_store = (kind == ttyld_pkg::K_NORMAL) || (kind == ttyld_pkg::K_ERASE) ||
                      (kind == ttyld_pkg::K_KILL) || (kind == ttyld_pkg::K_WERASE) ||
                      (kind == ttyld_pkg::K_EOF);
        r_push  = i_cmd.decode && typed_store && (r_rcnt != RCW'(RAW_DEPTH));
        l_push  = i_cmd.decode && canon &&
                  ((kind == ttyld_pkg::K_NORMAL) || (kind == ttyld_pkg::K_EOF)) &&
                  (r_lcnt != LCW'(LINE_DEPTH));
        l_wdata = (kind == ttyld_pkg::K_EOF) ? ttyld_pkg::CH_NL : r_ch;
    end

    // line and raw memories
    logic [7:0] line_mem [LINE_DEPTH];
    logic [7:0] raw_mem  [RAW_DEPTH];
    logic [7:0] r_lrdata, r_rrdata;

    always_ff @(posedge i_clk) begin
        if (l_push) line_mem[l_wr_addr] <= l_wdata;
        r_lrdata <= line_mem[l_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (r_push) raw_mem[r_wr_addr] <= r_ch;
        r_rrdata <= raw_mem[r_rhead];
    end

    // scan stop test on the tail character
    logic blank, tail_stop;
    always_comb begin
        blank = (r_lrdata == ttyld_pkg::CH_SP) ||
                (r_lrdata >= ttyld_pkg::CH_HT && r_lrdata <= ttyld_pkg::CH_CR);
        tail_stop = (kind == ttyld_pkg::K_WERASE) ? blank
                                                  : (r_lrdata == ttyld_pkg::CH_NL);
    end

    // working result
    ttyld_pkg::t_out r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lhead  <= '0;
            r_lcnt   <= '0;
            r_lready <= 1'b0;
            r_rhead  <= '0;
            r_rcnt   <= '0;
        end else begin
            if (r_push) r_rcnt <= r_rcnt + RCW'(1);
            if (l_push) r_lcnt <= r_lcnt + LCW'(1);
            if (i_cmd.decode && canon) begin
                if (kind == ttyld_pkg::K_EOF) r_lready <= 1'b1;
                if (kind == ttyld_pkg::K_NORMAL && r_ch == ttyld_pkg::CH_NL) r_lready <= 1'b1;
            end
            if (i_cmd.scan_step) r_lcnt <= r_lcnt - LCW'(1);
            if (i_cmd.pop) begin
                if (kind == ttyld_pkg::K_RD_LINE) begin
                    r_lhead <= l_head_inc;
                    r_lcnt  <= r_lcnt - LCW'(1);
                    if (r_lrdata == ttyld_pkg::CH_NL) r_lready <= 1'b0;
                end else begin
                    r_rhead <= r_head_inc;
                    r_rcnt  <= r_rcnt - RCW'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_res <= '0;
        end else begin
            if (i_cmd.decode) begin
                case (kind)
                    ttyld_pkg::K_SIG_INTR: r_res.signal_kind <= ttyld_pkg::SIG_INTR;
                    ttyld_pkg::K_SIG_QUIT: r_res.signal_kind <= ttyld_pkg::SIG_QUIT;
                    ttyld_pkg::K_EOF:      r_res.wake_reader <= 1'b1;
                    ttyld_pkg::K_NORMAL: begin
                        if (r_mode[ttyld_pkg::F_ECHO]) begin
                            r_res.echo_valid <= 1'b1;
                            r_res.echo_char  <= r_ch;
                        end
                        r_res.wake_reader <= canon &&
                                             (r_lready || r_ch == ttyld_pkg::CH_NL);
                    end
                    default: ;
                endcase
            end
            if (i_cmd.scan_step && r_res.erase_count != ttyld_pkg::ERASE_MAX) begin
                r_res.erase_count <= r_res.erase_count + 9'd1;
            end
            if (i_cmd.pop) begin
                r_res.read_valid <= 1'b1;
                r_res.read_char  <= (kind == ttyld_pkg::K_RD_LINE) ? r_lrdata : r_rrdata;
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_out_valid <= 1'b0;
        end else if (i_cmd.finish) begin
            o_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            o_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) o_out <= r_res;
    end

    always_comb begin
        o_status.kind       = kind;
        o_status.line_empty = (r_lcnt == '0);
        o_status.scan_stop  = tail_stop;
        o_status.out_busy   = o_out_valid && i_out_stall;
    end

endmodule

[hdl/tty_canonical_line_discipline.sv]
// Path: a plain character, signal or empty read goes through DECODE and FINISH; a read that
// returns a character also passes READ_DONE; erase, kill and word erase scan the line tail in
// SCAN_RD and SCAN_CHK, one character per pass, until the line empties or the scan stops on a
// newline (a blank for word erase); a single erase deletes at most one. A stalled result holds
// the next one in FINISH. Throughput: one item at a time; the next item is taken the cycle after the
// result is registered, so the per-character tail scan through the line memory sets the worst case.
// Reset: synchronous, active low; queues empty, settings at their defaults, no clearing pass.
module tty_canonical_line_discipline #(
    parameter int LINE_DEPTH = ttyld_pkg::LINE_DEPTH_DEF,
    parameter int RAW_DEPTH  = ttyld_pkg::RAW_DEPTH_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_stall,
    input  ttyld_pkg::t_in  i_in,
    output logic            o_out_valid,
    input  logic            i_out_stall,
    output ttyld_pkg::t_out o_out,
    input  logic            i_cfg_valid,
    output logic            o_cfg_ready,
    input  logic [2:0]      i_cfg_index,
    input  logic [7:0]      i_cfg_data
);

    ttyld_pkg::t_cmd    cmd;
    ttyld_pkg::t_status status;
    logic               idle;

    assign o_in_stall  = !idle;
    assign o_cfg_ready = 1'b1;

    ttyld_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_status   (status),
        .o_cmd      (cmd),
        .o_idle     (idle)
    );

    ttyld_dpath #(
        .LINE_DEPTH (LINE_DEPTH),
        .RAW_DEPTH  (RAW_DEPTH)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_out_stall (i_out_stall),
        .i_cmd       (cmd),
        .o_status    (status),
        .o_out_valid (o_out_valid),
        .o_out       (o_out)
    );

    // an accepted item blocks the input until its result is registered
    a_busy_after_transfer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("input not stalled after transfer");

    // a result never both echoes and returns a read character
    a_echo_read_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_out.echo_valid && o_out.read_valid))
        else $error("echo and read in one result");

    // a swallowed signal character has no other effect
    a_signal_alone: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out.signal_kind != ttyld_pkg::SIG_NONE |->
            !o_out.echo_valid && o_out.erase_count == 9'd0 && !o_out.read_valid)
        else $error("signal result carries other fields");

    // at most one full line's worth can be erased
    a_erase_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out.erase_count <= 9'(LINE_DEPTH))
        else $error("erase count beyond queue depth");

endmodule

[bench/tb_tty_canonical_line_discipline.sv]
// Self-checking testbench for the canonical line discipline: random and directed keystrokes
`timescale 1ns / 1ps

// Line discipline predictor with a queue of expected results
class line_discipline_scoreboard;
    bit [4:0] mode;
    bit [7:0] intr_c, quit_c, erase_c, kill_c, werase_c, eof_c;
    bit [7:0] line_mem [256];
    int unsigned line_hd, line_cnt;
    bit line_full;
    bit [7:0] raw_mem [256];
    int unsigned raw_hd, raw_cnt;
    ttyld_pkg::t_out pending_results [$];
    int unsigned fail_count;
    int unsigned checked;

    function new();
        mode = 5'd15; intr_c = 8'd3; quit_c = 8'd28; erase_c = 8'd127;
        kill_c = 8'd21; werase_c = 8'd23; eof_c = 8'd4;
        line_hd = 0; line_cnt = 0; line_full = 0; raw_hd = 0; raw_cnt = 0;
        fail_count = 0; checked = 0;
    endfunction

    function void set_reg(bit [2:0] idx, bit [7:0] val);
        case (idx)
            ttyld_pkg::REG_MODE:   mode = val[4:0];
            ttyld_pkg::REG_INTR:   intr_c = val;
            ttyld_pkg::REG_QUIT:   quit_c = val;
            ttyld_pkg::REG_ERASE:  erase_c = val;
            ttyld_pkg::REG_KILL:   kill_c = val;
            ttyld_pkg::REG_WERASE: werase_c = val;
            ttyld_pkg::REG_EOF:    eof_c = val;
            default: ;
        endcase
    endfunction

    function bit [7:0] line_last();
        return line_mem[(line_hd + line_cnt - 1) % 256];
    endfunction

    function void line_add(bit [7:0] c);
        if (line_cnt < 256) begin
            line_mem[(line_hd + line_cnt) % 256] = c;
            line_cnt++;
        end
    endfunction

    // Predict the result of one accepted item
    function void note_input(ttyld_pkg::t_in it);
        ttyld_pkg::t_out r;
        bit [7:0] ch;
        bit handled;
        bit canon;
        r = '0;
        handled = 0;
        canon = mode[ttyld_pkg::F_CANON];
        if (it.operation == ttyld_pkg::OP_READ) begin
            if (canon) begin
                if (line_cnt != 0 && line_full) begin
                    r.read_char = line_mem[line_hd];
                    line_hd = (line_hd + 1) % 256;
                    line_cnt--;
                    r.read_valid = 1;
                    if (r.read_char == ttyld_pkg::CH_NL) line_full = 0;
                end
            end else if (raw_cnt != 0) begin
                r.read_char = raw_mem[raw_hd];
                raw_hd = (raw_hd + 1) % 256;
                raw_cnt--;
                r.read_valid = 1;
            end
        end else begin
            ch = it.in_char;
            if (ch == ttyld_pkg::CH_NL && mode[ttyld_pkg::F_NLCR]) ch = ttyld_pkg::CH_CR;
            if (ch == ttyld_pkg::CH_CR && mode[ttyld_pkg::F_CRNL]) ch = ttyld_pkg::CH_NL;
            if (mode[ttyld_pkg::F_SIG]) begin
                if (ch == intr_c) begin
                    r.signal_kind = ttyld_pkg::SIG_INTR; handled = 1;
                end else if (ch == quit_c) begin
                    r.signal_kind = ttyld_pkg::SIG_QUIT; handled = 1;
                end
            end
            if (!handled) begin
                if (raw_cnt < 256) begin
                    raw_mem[(raw_hd + raw_cnt) % 256] = ch;
                    raw_cnt++;
                end
                if (canon) begin
                    if (ch == erase_c || ch == ttyld_pkg::CH_BS) begin
                        if (line_cnt != 0 && line_last() != ttyld_pkg::CH_NL) begin
                            line_cnt--; r.erase_count = 1;
                        end
                        handled = 1;
                    end else if (ch == kill_c) begin
                        while (line_cnt != 0 && line_last() != ttyld_pkg::CH_NL) begin
                            line_cnt--;
                            if (r.erase_count < ttyld_pkg::ERASE_MAX) r.erase_count++;
                        end
                        handled = 1;
                    end else if (ch == werase_c) begin
                        while (line_cnt != 0 && !(line_last() == ttyld_pkg::CH_SP ||
                               (line_last() >= ttyld_pkg::CH_HT &&
                                line_last() <= ttyld_pkg::CH_CR))) begin
                            line_cnt--;
                            if (r.erase_count < ttyld_pkg::ERASE_MAX) r.erase_count++;
                        end
                        handled = 1;
                    end else if (ch == eof_c) begin
                        line_add(ttyld_pkg::CH_NL);
                        line_full = 1; r.wake_reader = 1; handled = 1;
                    end
                end
            end
            if (!handled) begin
                if (mode[ttyld_pkg::F_ECHO]) begin
                    r.echo_valid = 1; r.echo_char = ch;
                end
                if (canon) begin
                    if (ch == ttyld_pkg::CH_NL) line_full = 1;
                    line_add(ch);
                    if (line_full) r.wake_reader = 1;
                end
            end
        end
        pending_results.push_back(r);
    endfunction

    // Compare one result with the oldest prediction
    function void check_result(ttyld_pkg::t_out got);
        ttyld_pkg::t_out exp_r;
        if (pending_results.size() == 0) begin
            $error("unexpected result %h", got);
            fail_count++;
            return;
        end
        exp_r = pending_results.pop_front();
        checked++;
        if (got.echo_valid !== exp_r.echo_valid) begin
            $error("echo_valid exp %0d got %0d", exp_r.echo_valid, got.echo_valid);
            fail_count++;
        end
        if (got.echo_char !== exp_r.echo_char) begin
            $error("echo_char exp %0d got %0d", exp_r.echo_char, got.echo_char);
            fail_count++;
        end
        if (got.erase_count !== exp_r.erase_count) begin
            $error("erase_count exp %0d got %0d", exp_r.erase_count, got.erase_count);
            fail_count++;
        end
        if (got.read_valid !== exp_r.read_valid) begin
            $error("read_valid exp %0d got %0d", exp_r.read_valid, got.read_valid);
            fail_count++;
        end
        if (got.read_char !== exp_r.read_char) begin
            $error("read_char exp %0d got %0d", exp_r.read_char, got.read_char);
            fail_count++;
        end
        if (got.wake_reader !== exp_r.wake_reader) begin
            $error("wake_reader exp %0d got %0d", exp_r.wake_reader, got.wake_reader);
            fail_count++;
        end
        if (got.signal_kind !== exp_r.signal_kind) begin
            $error("signal_kind exp %0d got %0d", exp_r.signal_kind, got.signal_kind);
            fail_count++;
        end
    endfunction
endclass

module tb_tty_canonical_line_discipline;
    localparam int STALL_LIMIT = 20000;
    // index past the last register, must be ignored
    localparam logic [2:0] REG_UNUSED = 3'd7;

    logic            i_clk;
    logic            i_rst_n;
    logic            i_in_valid;
    logic            o_in_stall;
    ttyld_pkg::t_in  i_in;
    logic            o_out_valid;
    logic            i_out_stall;
    ttyld_pkg::t_out o_out;
    logic            i_cfg_valid;
    logic            o_cfg_ready;
    logic [2:0]      i_cfg_index;
    logic [7:0]      i_cfg_data;

    line_discipline_scoreboard sb;
    bit  idle_enable;
    bit  hold_receiver;
    int  hold_cycles;
    int  quiet_cycles;
    int  typed_count, read_count;

    tty_canonical_line_discipline dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_stall(o_in_stall), .i_in(i_in),
        .o_out_valid(o_out_valid), .i_out_stall(i_out_stall), .o_out(o_out),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data)
    );

    initial begin
        i_clk = 0;
        forever #4 i_clk = ~i_clk;
    end

    // Offer one item and wait for its transfer; valid stays up for a following item
    task automatic send_item(bit op, bit [7:0] c);
        int gap;
        if (idle_enable && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 3);
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in <= '{operation: op, in_char: c};
        do @(posedge i_clk); while (o_in_stall);
        sb.note_input('{operation: op, in_char: c});
        if (op == ttyld_pkg::OP_READ) read_count++; else typed_count++;
    endtask

    task automatic send_text(string s);
        for (int k = 0; k < s.len(); k++) send_item(ttyld_pkg::OP_CHAR, s[k]);
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (sb.pending_results.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic write_reg(bit [2:0] idx, bit [7:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.set_reg(idx, val);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic set_defaults(bit [4:0] m);
        write_reg(ttyld_pkg::REG_MODE, {3'b0, m});
        write_reg(ttyld_pkg::REG_INTR, 8'd3);
        write_reg(ttyld_pkg::REG_QUIT, 8'd28);
        write_reg(ttyld_pkg::REG_ERASE, 8'd127);
        write_reg(ttyld_pkg::REG_KILL, 8'd21);
        write_reg(ttyld_pkg::REG_WERASE, 8'd23);
        write_reg(ttyld_pkg::REG_EOF, 8'd4);
    endtask

    // Mostly printable text and line endings, some control characters
    function automatic bit [7:0] pick_char();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 8'($urandom_range(97, 122));
        if (r < 62) return ttyld_pkg::CH_SP;
        if (r < 70) return ttyld_pkg::CH_NL;
        if (r < 73) return ttyld_pkg::CH_CR;
        if (r < 76) return sb.erase_c;
        if (r < 78) return ttyld_pkg::CH_BS;
        if (r < 80) return sb.kill_c;
        if (r < 84) return sb.werase_c;
        if (r < 86) return sb.eof_c;
        if (r < 88) return sb.intr_c;
        if (r < 90) return sb.quit_c;
        return 8'($urandom_range(0, 255));
    endfunction

    task automatic random_phase(int n);
        for (int k = 0; k < n; k++) begin
            if ($urandom_range(0, 99) < 40)
                send_item(ttyld_pkg::OP_READ, 8'($urandom_range(0, 255)));
            else
                send_item(ttyld_pkg::OP_CHAR, pick_char());
        end
    endtask

    // Receiver: random stall bursts plus one long hold-off
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
            hold_cycles <= 0;
        end else if (hold_receiver) begin
            i_out_stall <= 1'b1;
            hold_cycles <= hold_cycles + 1;
        end else if (hold_cycles > 0 && i_out_stall && idle_enable) begin
            hold_cycles <= hold_cycles - 1;
            if (hold_cycles == 1) i_out_stall <= 1'b0;
        end else if (idle_enable && !i_out_stall && $urandom_range(0, 6) == 0) begin
            i_out_stall <= 1'b1;
            hold_cycles <= $urandom_range(1, 3);
        end else begin
            i_out_stall <= 1'b0;
            hold_cycles <= 0;
        end
    end

    // Result check and watchdog
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) sb.check_result(o_out);
            if ((o_out_valid && !i_out_stall) || (i_in_valid && !o_in_stall) || hold_receiver)
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    initial begin
        sb = new();
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_in = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = ttyld_pkg::REG_MODE;
        i_cfg_data = '0;
        idle_enable = 1'b0;
        hold_receiver = 1'b0;
        quiet_cycles = 0;
        typed_count = 0;
        read_count = 0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: editing, signals, end of file, empty reads, extreme codes
        send_item(ttyld_pkg::OP_READ, 8'hFF);
        send_text("ab cd");
        send_item(ttyld_pkg::OP_CHAR, 8'd23);
        send_item(ttyld_pkg::OP_CHAR, 8'd127);
        send_item(ttyld_pkg::OP_CHAR, ttyld_pkg::CH_BS);
        send_item(ttyld_pkg::OP_CHAR, 8'd21);
        send_item(ttyld_pkg::OP_CHAR, 8'd3);
        send_item(ttyld_pkg::OP_CHAR, 8'd28);
        send_text("xy");
        send_item(ttyld_pkg::OP_CHAR, ttyld_pkg::CH_CR);
        send_item(ttyld_pkg::OP_CHAR, 8'd127);
        send_item(ttyld_pkg::OP_CHAR, 8'hFF);
        send_item(ttyld_pkg::OP_CHAR, 8'h00);
        send_item(ttyld_pkg::OP_CHAR, 8'd4);
        repeat (6) send_item(ttyld_pkg::OP_READ, 8'h00);
        wait_drained();

        // Every register, including extremes; NL and CR mapping both ways
        write_reg(ttyld_pkg::REG_MODE, 8'd31);
        write_reg(ttyld_pkg::REG_INTR, 8'd255);
        write_reg(ttyld_pkg::REG_QUIT, 8'd0);
        write_reg(ttyld_pkg::REG_ERASE, 8'd255);
        write_reg(ttyld_pkg::REG_KILL, 8'd0);
        write_reg(ttyld_pkg::REG_WERASE, 8'd255);
        write_reg(ttyld_pkg::REG_EOF, 8'd0);
        write_reg(REG_UNUSED, 8'hAA);
        send_text("q\n\r");
        send_item(ttyld_pkg::OP_CHAR, 8'hFF);
        send_item(ttyld_pkg::OP_CHAR, 8'h00);
        repeat (4) send_item(ttyld_pkg::OP_READ, 8'h55);
        wait_drained();

        // Random, default controls, idling on
        idle_enable = 1'b1;
        set_defaults(5'd15);
        random_phase(300);

        // Hold off the receiver while the sender keeps offering
        fork
            random_phase(40);
            begin
                hold_receiver = 1'b1;
                repeat (200) @(posedge i_clk);
                hold_receiver = 1'b0;
            end
        join
        wait_drained();

        // Long line overflows the line queue; word erase and kill then delete long runs of it
        write_reg(ttyld_pkg::REG_MODE, 8'd1);
        for (int k = 0; k < 270; k++)
            send_item(ttyld_pkg::OP_CHAR, 8'($urandom_range(33, 126)));
        send_item(ttyld_pkg::OP_CHAR, 8'd23);
        for (int k = 0; k < 270; k++)
            send_item(ttyld_pkg::OP_CHAR, 8'($urandom_range(0, 255)));
        send_item(ttyld_pkg::OP_CHAR, 8'd21);
        wait_drained();

        // Non-canonical raw queue, no echo, no signals
        write_reg(ttyld_pkg::REG_MODE, 8'd0);
        random_phase(250);
        wait_drained();

        // Random modes and control characters
        for (int p = 0; p < 4; p++) begin
            write_reg(ttyld_pkg::REG_MODE, 8'($urandom_range(0, 31)));
            write_reg(3'($urandom_range(1, 6)), 8'($urandom_range(0, 255)));
            random_phase(80);
            wait_drained();
        end

        // Final stretch without idling
        set_defaults(5'd15);
        idle_enable = 1'b0;
        random_phase(250);
        wait_drained();

        $display("Run covered %0d typed characters and %0d reads, %0d results checked",
                 typed_count, read_count, sb.checked);
        $display("Modes covered: canonical editing, signals, mapping, raw reads, overflow");
        if (sb.fail_count == 0 && sb.pending_results.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end
endmodule
